>>> src/llqm_pkg.sv
// package for the linked list queue manager: field widths, command codes
// and default sizes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package llqm_pkg;

    localparam int NUM_QUEUES_DEF = 16;
    localparam int NUM_NODES_DEF  = 256;

    localparam int CMD_W  = 2;
    localparam int QIDX_W = 4;
    localparam int NIDX_W = 8;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PREPEND     = 2'd0,
        CMD_APPEND      = 2'd1,
        CMD_REMOVE_HEAD = 2'd2,
        CMD_REMOVE_NODE = 2'd3
    } cmd_t;

endpackage

`default_nettype wire

>>> src/llqm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module llqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/linked_list_queue_manager.sv
// top level of the linked list queue manager: queue head/tail ram, node
// next/prev rams and the command sequencer; uses llqm_pkg and llqm_ram
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   cmd, queue_index, node_index
//  m_axis    out  m_axis_tvalid / m_axis_tready   removed_valid, removed_node, queue_empty
//
//  each request runs a read step, then the first and the second write step; remove
//  first adds a dependent read of the next ram at the old head after the read step
//  one request at a time: the sequencer owns the single ports of the three rams
//  after reset every entry of the queue ram is swept to null, not ready meanwhile
//  a result waits in the output register while the next request is accepted;
//  the sequencer holds its last step until that register is free

module linked_list_queue_manager #(
    parameter int NUM_QUEUES = llqm_pkg::NUM_QUEUES_DEF,
    parameter int NUM_NODES  = llqm_pkg::NUM_NODES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [1:0] cmd, [5:2] queue_index, [13:6] node_index, [15:14] zero
    input  wire logic [llqm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] removed_valid, [8:1] removed_node, [9] queue_empty, [15:10] zero
    output logic      [llqm_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NW  = $clog2(NUM_NODES);
    localparam int LW  = NW + 1;
    localparam int QAW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QEW = 2 * LW;
    localparam int QI  = llqm_pkg::QIDX_W;
    localparam int NI  = llqm_pkg::NIDX_W;
    localparam int CW  = llqm_pkg::CMD_W;

    // link: present bit on top, node index below; all zero is null
    typedef logic [LW-1:0] link_t;

    typedef struct packed {
        logic          we;
        logic [NW-1:0] addr;
        link_t         data;
    } link_wr_t;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD    = 6'b000100,
        ST_RD2   = 6'b001000,
        ST_WR1   = 6'b010000,
        ST_WR2   = 6'b100000
    } state_t;

    function automatic logic link_ok(input link_t l);
        return l[LW-1] && (32'(l[NW-1:0]) < NUM_NODES);
    endfunction

    state_t           state_reg, state_next;
    logic [QAW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic             m_valid_reg, m_valid_next;

    llqm_pkg::cmd_t   cmd_reg;
    logic [QI-1:0]    q_reg;
    logic [NI-1:0]    n_reg;
    logic             bad_q_reg;
    logic             node_ok_reg;
    link_t            head_reg, tail_reg, nn_reg, np_reg;
    link_wr_t         w2n_reg, w2n_next;
    link_wr_t         w2p_reg, w2p_next;
    logic             res_valid_reg, res_valid_next;
    logic [NI-1:0]    res_node_reg, res_node_next;
    logic             res_empty_reg, res_empty_next;
    logic [llqm_pkg::M_TDATA_W-1:0] m_data_reg;

    logic             accept;
    logic             out_load;
    logic [QI-1:0]    in_q;
    logic [NI-1:0]    in_n;

    link_t            self_l, nx_l, pv_l, new_head, new_tail;
    link_wr_t         w1n, w1p, next_wr, prev_wr;

    logic             q_we;
    logic [QAW-1:0]   q_waddr, q_raddr;
    logic [QEW-1:0]   q_wdata, q_rdata;
    logic [NW-1:0]    next_raddr, prev_raddr;
    link_t            next_rdata, prev_rdata;

    assign in_q     = s_axis_tdata[CW +: QI];
    assign in_n     = s_axis_tdata[CW+QI +: NI];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_WR2) && (!m_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == QAW'(NUM_QUEUES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (cmd_reg == llqm_pkg::CMD_REMOVE_HEAD)
                begin
                    state_next = ST_RD2;
                end
                else
                begin
                    state_next = ST_WR1;
                end
            end
            ST_RD2:  state_next = ST_WR1;
            ST_WR1:  state_next = ST_WR2;
            ST_WR2:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // link update for the first write step and the plan for the second
    always_comb
    begin
        self_l   = {1'b1, NW'(n_reg)};
        nx_l     = link_ok(nn_reg) ? nn_reg : '0;
        pv_l     = link_ok(np_reg) ? np_reg : '0;
        new_head = head_reg;
        new_tail = tail_reg;
        w1n      = '0;
        w1p      = '0;
        w2n_next = '0;
        w2p_next = '0;
        res_valid_next = 1'b0;
        res_node_next  = '0;
        if (!bad_q_reg)
        begin
            case (cmd_reg)
                llqm_pkg::CMD_PREPEND:
                begin
                    if (node_ok_reg)
                    begin
                        w1p = '{we: 1'b1, addr: NW'(n_reg), data: '0};
                        w1n = '{we: 1'b1, addr: NW'(n_reg),
                                data: head_reg[LW-1] ? head_reg : '0};
                        new_head = self_l;
                        if (!tail_reg[LW-1])
                        begin
                            new_tail = self_l;
                        end
                        w2p_next = '{we: link_ok(head_reg), addr: head_reg[NW-1:0],
                                     data: self_l};
                    end
                end
                llqm_pkg::CMD_APPEND:
                begin
                    if (node_ok_reg)
                    begin
                        w1n = '{we: 1'b1, addr: NW'(n_reg), data: '0};
                        w1p = '{we: 1'b1, addr: NW'(n_reg),
                                data: tail_reg[LW-1] ? tail_reg : '0};
                        new_tail = self_l;
                        if (!head_reg[LW-1])
                        begin
                            new_head = self_l;
                        end
                        w2n_next = '{we: link_ok(tail_reg), addr: tail_reg[NW-1:0],
                                     data: self_l};
                    end
                end
                llqm_pkg::CMD_REMOVE_HEAD:
                begin
                    if (link_ok(head_reg))
                    begin
                        // nn_reg holds the next link of the old head here
                        if (link_ok(nn_reg))
                        begin
                            new_head = nn_reg;
                            w2p_next = '{we: 1'b1, addr: nn_reg[NW-1:0], data: '0};
                        end
                        else
                        begin
                            new_head = '0;
                            new_tail = '0;
                        end
                        w1n = '{we: 1'b1, addr: head_reg[NW-1:0], data: '0};
                        w1p = '{we: 1'b1, addr: head_reg[NW-1:0], data: '0};
                        res_valid_next = 1'b1;
                        res_node_next  = NI'(head_reg[NW-1:0]);
                    end
                end
                llqm_pkg::CMD_REMOVE_NODE:
                begin
                    if (node_ok_reg)
                    begin
                        if (head_reg == self_l)
                        begin
                            new_head = nx_l;
                        end
                        if (tail_reg == self_l)
                        begin
                            new_tail = pv_l;
                        end
                        w1n = '{we: (pv_l != '0), addr: pv_l[NW-1:0], data: nx_l};
                        w1p = '{we: (nx_l != '0), addr: nx_l[NW-1:0], data: pv_l};
                        // own links cleared last so they win over a self loop
                        w2n_next = '{we: 1'b1, addr: NW'(n_reg), data: '0};
                        w2p_next = '{we: 1'b1, addr: NW'(n_reg), data: '0};
                        res_valid_next = 1'b1;
                        res_node_next  = n_reg;
                    end
                end
                default: ;
            endcase
        end
        res_empty_next = bad_q_reg || !new_head[LW-1];
    end

    // ram port selection
    always_comb
    begin
        next_wr = '0;
        prev_wr = '0;
        if (state_reg == ST_WR1)
        begin
            next_wr = w1n;
            prev_wr = w1p;
        end
        else if (state_reg == ST_WR2)
        begin
            next_wr = w2n_reg;
            prev_wr = w2p_reg;
        end
    end

    assign q_we       = (state_reg == ST_CLEAR) || ((state_reg == ST_WR1) && !bad_q_reg);
    assign q_waddr    = (state_reg == ST_CLEAR) ? clr_cnt_reg : QAW'(q_reg);
    assign q_wdata    = (state_reg == ST_CLEAR) ? '0 : {new_tail, new_head};
    assign q_raddr    = QAW'(in_q);
    assign prev_raddr = NW'(in_n);
    // in the read step the old head indexes the second next read
    assign next_raddr = (state_reg == ST_IDLE) ? NW'(in_n) : q_rdata[NW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= llqm_pkg::cmd_t'(s_axis_tdata[CW-1:0]);
            q_reg       <= in_q;
            n_reg       <= in_n;
            bad_q_reg   <= !(32'(in_q) < NUM_QUEUES);
            node_ok_reg <= 32'(in_n) < NUM_NODES;
        end
        if (state_reg == ST_RD)
        begin
            head_reg <= q_rdata[LW-1:0];
            tail_reg <= q_rdata[QEW-1:LW];
            nn_reg   <= next_rdata;
            np_reg   <= prev_rdata;
        end
        if (state_reg == ST_RD2)
        begin
            nn_reg <= next_rdata;
        end
        if (state_reg == ST_WR1)
        begin
            w2n_reg       <= w2n_next;
            w2p_reg       <= w2p_next;
            res_valid_reg <= res_valid_next;
            res_node_reg  <= res_node_next;
            res_empty_reg <= res_empty_next;
        end
        if (out_load)
        begin
            m_data_reg <= {6'd0, res_empty_reg, res_node_reg, res_valid_reg};
        end
    end

    llqm_ram #(
        .WIDTH (QEW),
        .DEPTH (NUM_QUEUES)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    llqm_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_wr.we),
        .waddr (next_wr.addr),
        .wdata (next_wr.data),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    llqm_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_NODES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_wr.we),
        .waddr (prev_wr.addr),
        .wdata (prev_wr.data),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("request accepted while one is in flight");

    // a result appears only from the last step of the sequencer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_WR2))
        else $error("result loaded outside the final step");

    // no removal reported means a zero node index
    a_zero_node: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[8:1] == '0))
        else $error("node index set without a removal");

    // link rams are only written in the two write steps
    a_quiet_rams: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_RD || state_reg == ST_RD2)
            |-> (!next_wr.we && !prev_wr.we && !q_we))
        else $error("ram written while reading");

endmodule

`default_nettype wire

>>> verif/llqm_checker.sv
// scoreboard for the linked list queue manager: watches both stream channels,
// keeps its own copy of the queue and node links, and compares every result
// depends on llqm_pkg
`timescale 1ns / 1ps

module llqm_checker #(
    parameter int NUM_QUEUES = llqm_pkg::NUM_QUEUES_DEF,
    parameter int NUM_NODES  = llqm_pkg::NUM_NODES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [llqm_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [llqm_pkg::M_TDATA_W-1:0] m_tdata,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_seen
);

    import llqm_pkg::*;

    localparam int Q_LO = CMD_W;
    localparam int N_LO = CMD_W + QIDX_W;

    // packed in the order of m_tdata, highest field first
    typedef struct packed {
        logic              queue_empty;
        logic [NIDX_W-1:0] removed_node;
        logic              removed_valid;
    } outcome_t;

    // link: top bit says present, low bits hold the node index
    typedef logic [NIDX_W:0] link_t;
    localparam link_t NULL_LINK = '0;

    link_t    q_head [NUM_QUEUES];
    link_t    q_tail [NUM_QUEUES];
    link_t    n_next [NUM_NODES];
    link_t    n_prev [NUM_NODES];
    outcome_t awaited_outcomes[$];
    outcome_t got;
    outcome_t want;

    function automatic bit usable(input link_t l);
        return l[NIDX_W] && (int'(l[NIDX_W-1:0]) < NUM_NODES);
    endfunction

    function automatic link_t to_link(input logic [NIDX_W-1:0] n);
        return {1'b1, n};
    endfunction

    // applies one request to the shadow lists and returns the result it gives
    function automatic outcome_t predict_queue_op(input cmd_t op,
                                                  input logic [QIDX_W-1:0] qi,
                                                  input logic [NIDX_W-1:0] ni);
        outcome_t res;
        link_t    h;
        link_t    t;
        link_t    nx;
        link_t    pv;
        link_t    self_link;
        bit       node_ok;
        res     = '0;
        node_ok = int'(ni) < NUM_NODES;
        if (int'(qi) >= NUM_QUEUES)
        begin
            res.queue_empty = 1'b1;
            return res;
        end
        case (op)
            CMD_PREPEND:
                if (node_ok)
                begin
                    h          = q_head[qi];
                    n_prev[ni] = NULL_LINK;
                    if (usable(h))
                        n_prev[h[NIDX_W-1:0]] = to_link(ni);
                    if (!q_tail[qi][NIDX_W])
                        q_tail[qi] = to_link(ni);
                    n_next[ni] = h[NIDX_W] ? h : NULL_LINK;
                    q_head[qi] = to_link(ni);
                end
            CMD_APPEND:
                if (node_ok)
                begin
                    t          = q_tail[qi];
                    n_next[ni] = NULL_LINK;
                    if (usable(t))
                        n_next[t[NIDX_W-1:0]] = to_link(ni);
                    if (!q_head[qi][NIDX_W])
                        q_head[qi] = to_link(ni);
                    n_prev[ni] = t[NIDX_W] ? t : NULL_LINK;
                    q_tail[qi] = to_link(ni);
                end
            CMD_REMOVE_HEAD:
            begin
                h = q_head[qi];
                if (usable(h))
                begin
                    nx = n_next[h[NIDX_W-1:0]];
                    if (usable(nx))
                    begin
                        q_head[qi]             = nx;
                        n_prev[nx[NIDX_W-1:0]] = NULL_LINK;
                    end
                    else
                    begin
                        q_head[qi] = NULL_LINK;
                        q_tail[qi] = NULL_LINK;
                    end
                    n_next[h[NIDX_W-1:0]] = NULL_LINK;
                    n_prev[h[NIDX_W-1:0]] = NULL_LINK;
                    res.removed_valid     = 1'b1;
                    res.removed_node      = h[NIDX_W-1:0];
                end
            end
            default:
                if (node_ok)
                begin
                    nx        = n_next[ni];
                    pv        = n_prev[ni];
                    self_link = to_link(ni);
                    if (!usable(nx))
                        nx = NULL_LINK;
                    if (!usable(pv))
                        pv = NULL_LINK;
                    // head and tail only move when they pointed at this node
                    if (q_head[qi] == self_link)
                        q_head[qi] = nx;
                    if (q_tail[qi] == self_link)
                        q_tail[qi] = pv;
                    if (pv != NULL_LINK)
                        n_next[pv[NIDX_W-1:0]] = nx;
                    if (nx != NULL_LINK)
                        n_prev[nx[NIDX_W-1:0]] = pv;
                    n_next[ni]        = NULL_LINK;
                    n_prev[ni]        = NULL_LINK;
                    res.removed_valid = 1'b1;
                    res.removed_node  = ni;
                end
        endcase
        res.queue_empty = !q_head[qi][NIDX_W];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                q_head[i] = NULL_LINK;
                q_tail[i] = NULL_LINK;
            end
            for (int i = 0; i < NUM_NODES; i++)
            begin
                n_next[i] = NULL_LINK;
                n_prev[i] = NULL_LINK;
            end
            awaited_outcomes.delete();
            mismatches   = 0;
            outstanding  = 0;
            results_seen = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_outcomes.push_back(predict_queue_op(cmd_t'(s_tdata[CMD_W-1:0]),
                                                            s_tdata[N_LO-1:Q_LO],
                                                            s_tdata[N_LO+NIDX_W-1:N_LO]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(outcome_t)-1:0];
                results_seen++;
                if (awaited_outcomes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result %h with no request waiting",
                                 $realtime, got);
                    mismatches++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (got.removed_valid !== want.removed_valid ||
                        got.removed_node !== want.removed_node ||
                        got.queue_empty !== want.queue_empty)
                    begin
                        if (mismatches < 10)
                            $display("%0t: res %0d exp/got valid %b/%b node %0d/%0d empty %b/%b",
                                     $realtime, results_seen,
                                     want.removed_valid, got.removed_valid,
                                     want.removed_node, got.removed_node,
                                     want.queue_empty, got.queue_empty);
                        mismatches++;
                    end
                end
            end
            outstanding = awaited_outcomes.size();
        end
    end

endmodule

>>> verif/tb_linked_list_queue_manager.sv
// testbench top for the linked list queue manager: clock, reset, request and
// result traffic, verdict; uses llqm_pkg, llqm_checker and the block itself
`timescale 1ns / 1ps

module tb_linked_list_queue_manager;

    import llqm_pkg::*;

    localparam int NQ = NUM_QUEUES_DEF;
    localparam int NN = NUM_NODES_DEF;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int results_seen;

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_sink    = 1'b0;

    // intended queue contents, exact as long as requests are well formed
    int members[NQ][$];
    int owner[NN];
    bit touched[NN];
    int cmd_count[4];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    linked_list_queue_manager #(
        .NUM_QUEUES (NQ),
        .NUM_NODES  (NN)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    llqm_checker #(
        .NUM_QUEUES (NQ),
        .NUM_NODES  (NN)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_axis_tvalid),
        .s_tready     (s_axis_tready),
        .s_tdata      (s_axis_tdata),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_tdata      (m_axis_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    function automatic void drop_from_mirror(input int ni);
        int qi;
        qi = owner[ni];
        if (qi >= 0)
        begin
            for (int i = 0; i < members[qi].size(); i++)
                if (members[qi][i] == ni)
                begin
                    members[qi].delete(i);
                    break;
                end
        end
        owner[ni] = -1;
    endfunction

    // linked picks a node in some queue, otherwise a free one
    function automatic int find_node(input bit linked, input bit need_touched);
        int start;
        int n;
        start = $urandom_range(0, NN - 1);
        for (int i = 0; i < NN; i++)
        begin
            n = (start + i) % NN;
            if (linked ? owner[n] >= 0 : (owner[n] < 0 && (touched[n] || !need_touched)))
                return n;
        end
        return -1;
    endfunction

    task automatic send_request(input cmd_t op, input int qi, input int ni);
        logic [QIDX_W-1:0] qv;
        logic [NIDX_W-1:0] nv;
        qv = qi[QIDX_W-1:0];
        nv = ni[NIDX_W-1:0];
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - CMD_W - QIDX_W - NIDX_W){1'b0}}, nv, qv, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        cmd_count[op]++;
        case (op)
            CMD_PREPEND, CMD_APPEND:
            begin
                drop_from_mirror(ni);
                if (op == CMD_PREPEND)
                    members[qi].push_front(ni);
                else
                    members[qi].push_back(ni);
                owner[ni]   = qi;
                touched[ni] = 1'b1;
            end
            CMD_REMOVE_HEAD:
                if (members[qi].size() > 0)
                begin
                    owner[members[qi][0]] = -1;
                    void'(members[qi].pop_front());
                end
            default:
                drop_from_mirror(ni);
        endcase
    endtask

    // well formed request with random content, a few harmless no-ops mixed in
    task automatic random_request(input int ins_pct);
        int qi;
        int ni;
        int pick;
        qi = $urandom_range(0, NQ - 1);
        ni = -1;
        if ($urandom_range(0, 99) < ins_pct)
            ni = find_node(1'b0, 1'b0);
        if (ni >= 0)
            send_request($urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND, qi, ni);
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick >= 5)
                ni = find_node(1'b1, 1'b0);
            // unlinking a node that sits in no queue changes nothing
            if (pick == 0)
                ni = find_node(1'b0, 1'b1);
            if (ni >= 0)
                send_request(CMD_REMOVE_NODE, (pick == 0) ? qi : owner[ni], ni);
            else
            begin
                for (int k = 0; k < 8 && pick != 0 && members[qi].size() == 0; k++)
                    qi = $urandom_range(0, NQ - 1);
                send_request(CMD_REMOVE_HEAD, qi, $urandom_range(0, NN - 1));
            end
        end
    endtask

    // misuse: relinking linked nodes and naming the wrong queue
    task automatic chaos_request();
        cmd_t op;
        int   ni;
        op = cmd_t'($urandom_range(0, 3));
        ni = $urandom_range(0, NN - 1);
        // never unlink a node whose links were never written
        for (int i = 0; i < NN && !touched[ni]; i++)
            ni = (ni + 1) % NN;
        if (op == CMD_REMOVE_NODE && !touched[ni])
            op = CMD_PREPEND;
        send_request(op, $urandom_range(0, NQ - 1), ni);
    endtask

    // result side: random back-pressure plus one long hold on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                for (int c = 0; c < 400; c++)
                    @(posedge clk);
                m_axis_tready <= 1'b1;
                hold_sink = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        foreach (owner[i])
            owner[i] = -1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // list edges on queue 0: empty insert, middle, head and tail removal
        send_request(CMD_PREPEND, 0, 0);
        send_request(CMD_APPEND, 0, 255);
        send_request(CMD_PREPEND, 0, 1);
        send_request(CMD_APPEND, 0, 2);
        send_request(CMD_REMOVE_NODE, 0, 0);
        send_request(CMD_REMOVE_NODE, 0, 1);
        send_request(CMD_REMOVE_NODE, 0, 2);
        send_request(CMD_REMOVE_HEAD, 0, 0);
        send_request(CMD_REMOVE_HEAD, 0, 255);
        // top queue, alternating bit patterns in the node index
        send_request(CMD_APPEND, 15, 128);
        send_request(CMD_PREPEND, 15, 127);
        send_request(CMD_APPEND, 15, 170);
        send_request(CMD_PREPEND, 15, 85);
        send_request(CMD_REMOVE_HEAD, 15, 0);
        send_request(CMD_REMOVE_HEAD, 15, 255);
        send_request(CMD_REMOVE_NODE, 15, 128);
        send_request(CMD_REMOVE_NODE, 15, 170);
        send_request(CMD_REMOVE_NODE, 9, 0);
        send_request(CMD_APPEND, 5, 255);
        send_request(CMD_APPEND, 10, 0);
        send_request(CMD_REMOVE_HEAD, 10, 0);
        send_request(CMD_REMOVE_HEAD, 5, 0);

        repeat (250) random_request(70);

        // block backs up behind a stalled result side
        hold_sink = 1'b1;
        repeat (30) random_request(60);

        repeat (300) random_request(50);

        // drain completely before going on
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);

        src_idle_on = 1'b0;
        repeat (150) random_request(35);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b0;
        repeat (100) random_request(50);
        src_idle_on = 1'b0;
        repeat (120) random_request(30);
        repeat (180) chaos_request();

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (20) @(posedge clk);

        $display("%0d requests: %0d prepend, %0d append, %0d remove-first, %0d remove-node",
                 cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
                 cmd_count[CMD_PREPEND], cmd_count[CMD_APPEND],
                 cmd_count[CMD_REMOVE_HEAD], cmd_count[CMD_REMOVE_NODE]);
        $display("%0d results checked across all queues, last ones with misused nodes",
                 results_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
